>>> rtl/core/wts_pkg.sv
// Shared types, constants and fixed tables for the wavetable tone sequencer.
// Used by the top level to load the waveform and note memories after reset.
`timescale 1ns / 1ps

package wts_pkg;

    localparam int WAVE_TABLE_LEN = 92;
    localparam int NOTE_TABLE_LEN = 72;
    localparam int RESET_UNIT_TICKS = 11;

    typedef struct packed {
        logic [7:0]  rate;
        logic [15:0] dur;
    } note_entry_t;

    localparam int NOTE_W = $bits(note_entry_t);

    function automatic logic [7:0] wave_value(input int idx);
        logic [7:0] v;
        case (idx)
            0: v = 8'h8a;  1: v = 8'hb1;  2: v = 8'h55;  3: v = 8'h4d;
            4: v = 8'hb2;  5: v = 8'h90;  6: v = 8'h43;  7: v = 8'h8f;
            8: v = 8'hb7;  9: v = 8'h4f;  10: v = 8'h54; 11: v = 8'hbd;
            12: v = 8'h8c; 13: v = 8'h35; 14: v = 8'h98; 15: v = 8'hb8;
            16: v = 8'h3a; 17: v = 8'h70; 18: v = 8'hcb; 19: v = 8'h4c;
            20: v = 8'h51; 21: v = 8'hd7; 22: v = 8'h5d; 23: v = 8'h47;
            24: v = 8'hd2; 25: v = 8'h69; 26: v = 8'h3a; 27: v = 8'hde;
            28: v = 8'h54; 29: v = 8'h4c; 30: v = 8'he4; 31: v = 8'h30;
            32: v = 8'h7b; 33: v = 8'hcf; 34: v = 8'h0f; 35: v = 8'hc5;
            36: v = 8'h82; 37: v = 8'h2e; 38: v = 8'hf3; 39: v = 8'h13;
            40: v = 8'hb2; 41: v = 8'h91; 42: v = 8'h2c; 43: v = 8'hf5;
            44: v = 8'h01; 45: v = 8'he0; 46: v = 8'h45; 47: v = 8'h83;
            48: v = 8'ha8; 49: v = 8'h2e; 50: v = 8'he9; 51: v = 8'h05;
            52: v = 8'hf6; 53: v = 8'h13; 54: v = 8'hd3; 55: v = 8'h47;
            56: v = 8'h96; 57: v = 8'h80; 58: v = 8'h61; 59: v = 8'hac;
            60: v = 8'h3e; 61: v = 8'hc9; 62: v = 8'h26; 63: v = 8'hdc;
            64: v = 8'h1d; 65: v = 8'hdc; 66: v = 8'h27; 67: v = 8'hc6;
            68: v = 8'h43; 69: v = 8'ha8; 70: v = 8'h60; 71: v = 8'h89;
            72: v = 8'h83; 73: v = 8'h65; 74: v = 8'hac; 75: v = 8'h40;
            76: v = 8'hc6; 77: v = 8'h30; 78: v = 8'hc2; 79: v = 8'h45;
            80: v = 8'ha0; 81: v = 8'h74; 82: v = 8'h6e; 83: v = 8'ha5;
            84: v = 8'h46; 85: v = 8'hba; 86: v = 8'h4b; 87: v = 8'h94;
            88: v = 8'h89; 89: v = 8'h56; 90: v = 8'hb7; 91: v = 8'h59;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic note_entry_t note_value(input int idx);
        note_entry_t e;
        case (idx)
            0: e = '{8'd100, 16'd280};  1: e = '{8'd150, 16'd250};
            2: e = '{8'd180, 16'd300};  3: e = '{8'd90, 16'd800};
            4: e = '{8'd120, 16'd500};  5: e = '{8'd200, 16'd50};
            6: e = '{8'd120, 16'd280};  7: e = '{8'd95, 16'd282};
            8: e = '{8'd90, 16'd285};   9: e = '{8'd180, 16'd350};
            10: e = '{8'd150, 16'd380}; 11: e = '{8'd120, 16'd280};
            12: e = '{8'd95, 16'd410};  13: e = '{8'd90, 16'd285};
            14: e = '{8'd70, 16'd500};  15: e = '{8'd200, 16'd50};
            16: e = '{8'd70, 16'd180};  17: e = '{8'd65, 16'd1000};
            18: e = '{8'd70, 16'd150};  19: e = '{8'd80, 16'd180};
            20: e = '{8'd90, 16'd285};  21: e = '{8'd80, 16'd270};
            22: e = '{8'd12, 16'd50};   23: e = '{8'd50, 16'd2000};
            24: e = '{8'd200, 16'd500}; 25: e = '{8'd80, 16'd500};
            26: e = '{8'd100, 16'd500}; 27: e = '{8'd255, 16'd800};
            28: e = '{8'd100, 16'd100}; 29: e = '{8'd96, 16'd100};
            30: e = '{8'd92, 16'd100};  31: e = '{8'd88, 16'd200};
            32: e = '{8'd84, 16'd250};  33: e = '{8'd80, 16'd300};
            34: e = '{8'd77, 16'd350};  35: e = '{8'd74, 16'd400};
            36: e = '{8'd71, 16'd200};  37: e = '{8'd68, 16'd200};
            38: e = '{8'd65, 16'd200};  39: e = '{8'd62, 16'd200};
            40: e = '{8'd59, 16'd190};  41: e = '{8'd56, 16'd180};
            42: e = '{8'd53, 16'd170};  43: e = '{8'd53, 16'd160};
            44: e = '{8'd50, 16'd150};  45: e = '{8'd48, 16'd140};
            46: e = '{8'd46, 16'd130};  47: e = '{8'd44, 16'd120};
            48: e = '{8'd42, 16'd110};  49: e = '{8'd40, 16'd100};
            50: e = '{8'd38, 16'd100};  51: e = '{8'd36, 16'd100};
            52: e = '{8'd34, 16'd100};  53: e = '{8'd32, 16'd100};
            54: e = '{8'd30, 16'd100};  55: e = '{8'd28, 16'd100};
            56: e = '{8'd26, 16'd100};  57: e = '{8'd24, 16'd100};
            58: e = '{8'd22, 16'd90};   59: e = '{8'd20, 16'd70};
            60: e = '{8'd18, 16'd60};   61: e = '{8'd16, 16'd50};
            62: e = '{8'd14, 16'd40};   63: e = '{8'd10, 16'd100};
            64: e = '{8'd16, 16'd50};   65: e = '{8'd20, 16'd70};
            66: e = '{8'd36, 16'd100};  67: e = '{8'd50, 16'd150};
            68: e = '{8'd62, 16'd200};  69: e = '{8'd71, 16'd200};
            70: e = '{8'd80, 16'd150};  71: e = '{8'd92, 16'd130};
            default: e = '{8'd0, 16'd0};
        endcase
        return e;
    endfunction

    // Red rule: rate is a multiple of 50 or of 20.
    function automatic logic red_rule(input logic [7:0] rate);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 255 / 20; k++) begin
            if (rate == 8'(k * 20)) hit = 1'b1;
        end
        for (int k = 0; k <= 255 / 50; k++) begin
            if (rate == 8'(k * 50)) hit = 1'b1;
        end
        return hit;
    endfunction

    // Green rule: a multiple of 40 is also one of 10, so only 10 matters.
    function automatic logic green_rule(input logic [7:0] rate);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 255 / 10; k++) begin
            if (rate == 8'(k * 10)) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/wavetable_tone_sequencer.sv
// Wavetable tone sequencer: steps a note song and plays a waveform as a PWM level.
// Depends on wts_pkg (tables, types) and wts_ram (waveform and note memories).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_valid/s_ready/s_tick carries one tick beat per accept;
//   a tick of 1 advances time, a tick of 0 only returns the current state.
//   Every input beat yields exactly one result beat on m_valid/m_ready with
//   the PWM level, the three LED bits, the note index and a sample-start flag.
//   The result of an accepted beat is registered and offered from the next
//   cycle on. Throughput is one beat per cycle while the receiver keeps up,
//   except that the cycle after a note change takes no beat while the note
//   memory returns the new note's rate and duration.
//   A stalled receiver holds the result; one more beat is taken behind it
//   only as the result is taken in the same cycle.
//   cfg_wr_en/cfg_wr_data write unit_ticks (reset value 11) at once.
// Reset:
//   After aresetn the block copies its fixed tables into the two memories,
//   one entry per cycle for max(WAVE_LEN, min(NOTE_COUNT, 72)) entries (92
//   with the defaults), then waits for the first note memory read; s_ready is low
//   meanwhile. Configuration writes are taken throughout.

module wavetable_tone_sequencer
    import wts_pkg::*;
#(
    parameter int WAVE_LEN   = 92,
    parameter int NOTE_COUNT = 72
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_tick,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pwm_level,
    output logic        m_red_led,
    output logic        m_green_led,
    output logic        m_blue_led,
    output logic [6:0]  m_note_number,
    output logic        m_sample_start
);

    localparam int SONG_LEN = (NOTE_COUNT < NOTE_TABLE_LEN) ? NOTE_COUNT : NOTE_TABLE_LEN;
    localparam int FILL_LEN = (WAVE_LEN > SONG_LEN) ? WAVE_LEN : SONG_LEN;
    localparam int WAW = $clog2(WAVE_LEN);
    localparam int NAW = (SONG_LEN > 1) ? $clog2(SONG_LEN) : 1;
    localparam int FW  = $clog2(FILL_LEN);
    localparam logic [WAW:0]  WAVE_LEN_W = WAVE_LEN[WAW:0];
    localparam logic [7:0]    SONG_LEN_W = SONG_LEN[7:0];
    localparam logic [FW-1:0] FILL_LAST  = FW'(FILL_LEN - 1);
    localparam logic [FW:0]   FILL_WAVE  = (FW + 1)'(WAVE_LEN);
    localparam logic [FW:0]   FILL_NOTE  = (FW + 1)'(SONG_LEN);

    // Configuration and control
    logic [16:0]    unit_ticks_reg;
    logic           fill_busy_reg, fill_busy_next;
    logic [FW-1:0]  fill_idx_reg, fill_idx_next;
    logic           pf_valid_reg, pf_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic           start_reg, start_next;

    // Sequencer state
    logic [16:0]    tick_count_reg, tick_count_next;
    logic [7:0]     hold_count_reg, hold_count_next;
    logic [15:0]    sample_count_reg, sample_count_next;
    logic [WAW-1:0] wave_pos_reg, wave_pos_next;
    logic [6:0]     note_pos_reg, note_pos_next;
    logic [2:0]     led_reg, led_next;

    logic           in_acc;
    logic           unit_end, hold_end, samp_end, wave_end, song_end, note_step;
    note_entry_t    cur_note;
    logic [NOTE_W-1:0] note_rd_data;
    logic [7:0]     wave_rd_data;
    logic [WAW-1:0] wave_rd_addr;

    assign s_ready = !fill_busy_reg && pf_valid_reg && (!out_valid_reg || m_ready);
    assign in_acc  = s_valid && s_ready;
    assign cur_note = note_entry_t'(note_rd_data);

    // Table memories: loaded by the sweep after reset, then only read.
    wts_ram #(
        .WIDTH (8),
        .DEPTH (WAVE_LEN)
    ) u_wave_ram (
        .aclk    (aclk),
        .wr_en   (fill_busy_reg && ({1'b0, fill_idx_reg} < FILL_WAVE)),
        .wr_addr (fill_idx_reg[WAW-1:0]),
        .wr_data (wave_value(int'(fill_idx_reg))),
        .rd_addr (wave_rd_addr),
        .rd_data (wave_rd_data)
    );

    wts_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (SONG_LEN)
    ) u_note_ram (
        .aclk    (aclk),
        .wr_en   (fill_busy_reg && ({1'b0, fill_idx_reg} < FILL_NOTE)),
        .wr_addr (fill_idx_reg[NAW-1:0]),
        .wr_data (note_value(int'(fill_idx_reg))),
        .rd_addr (note_pos_reg[NAW-1:0]),
        .rd_data (note_rd_data)
    );

    // Read the wave entry the state will hold after this edge, so the
    // read data always matches wave_pos_reg.
    assign wave_rd_addr = in_acc ? wave_pos_next : wave_pos_reg;

    always_comb begin
        unit_end  = ({1'b0, tick_count_reg} + 18'd1) >= {1'b0, unit_ticks_reg};
        hold_end  = ({1'b0, hold_count_reg} + 9'd1) >= {1'b0, cur_note.rate};
        samp_end  = ({1'b0, sample_count_reg} + 17'd1) >= {1'b0, cur_note.dur};
        wave_end  = ({1'b0, wave_pos_reg} + (WAW + 1)'(1)) >= WAVE_LEN_W;
        song_end  = ({1'b0, note_pos_reg} + 8'd1) >= SONG_LEN_W;
        note_step = s_tick && unit_end && hold_end && samp_end;
    end

    always_comb begin
        tick_count_next   = tick_count_reg;
        hold_count_next   = hold_count_reg;
        sample_count_next = sample_count_reg;
        wave_pos_next     = wave_pos_reg;
        note_pos_next     = note_pos_reg;
        led_next          = led_reg;
        start_next        = start_reg;
        if (in_acc) begin
            start_next = 1'b0;
            if (s_tick) begin
                if (unit_end) begin
                    tick_count_next = '0;
                    if (hold_end) begin
                        hold_count_next = '0;
                        start_next      = 1'b1;
                        if (wave_end) begin
                            wave_pos_next = '0;
                            led_next[0] = led_reg[0] ^ red_rule(cur_note.rate);
                            led_next[1] = led_reg[1] ^ green_rule(cur_note.rate);
                        end else begin
                            wave_pos_next = wave_pos_reg + WAW'(1);
                        end
                        if (samp_end) begin
                            sample_count_next = '0;
                            led_next[2]       = ~led_reg[2];
                            if (song_end) begin
                                note_pos_next = '0;
                                wave_pos_next = '0;
                            end else begin
                                note_pos_next = note_pos_reg + 7'd1;
                            end
                        end else begin
                            sample_count_next = sample_count_reg + 16'd1;
                        end
                    end else begin
                        hold_count_next = hold_count_reg + 8'd1;
                    end
                end else begin
                    tick_count_next = tick_count_reg + 17'd1;
                end
            end
        end
    end

    always_comb begin
        fill_busy_next = fill_busy_reg;
        fill_idx_next  = fill_idx_reg;
        if (fill_busy_reg) begin
            fill_idx_next = fill_idx_reg + FW'(1);
            if (fill_idx_reg == FILL_LAST) begin
                fill_busy_next = 1'b0;
            end
        end
        // Hold off input in the cycle after a note change while the new entry is read.
        pf_valid_next  = !fill_busy_reg && !(in_acc && note_step);
        out_valid_next = in_acc || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg   <= 17'(RESET_UNIT_TICKS);
            fill_busy_reg    <= 1'b1;
            fill_idx_reg     <= '0;
            pf_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            start_reg        <= 1'b0;
            tick_count_reg   <= '0;
            hold_count_reg   <= '0;
            sample_count_reg <= '0;
            wave_pos_reg     <= '0;
            note_pos_reg     <= '0;
            led_reg          <= '0;
        end else begin
            if (cfg_wr_en) begin
                unit_ticks_reg <= cfg_wr_data;
            end
            fill_busy_reg    <= fill_busy_next;
            fill_idx_reg     <= fill_idx_next;
            pf_valid_reg     <= pf_valid_next;
            out_valid_reg    <= out_valid_next;
            start_reg        <= start_next;
            tick_count_reg   <= tick_count_next;
            hold_count_reg   <= hold_count_next;
            sample_count_reg <= sample_count_next;
            wave_pos_reg     <= wave_pos_next;
            note_pos_reg     <= note_pos_next;
            led_reg          <= led_next;
        end
    end

    // The state registers are the result register: they change only on an
    // accepted beat, which needs the result slot free or being emptied.
    assign m_valid        = out_valid_reg;
    assign m_pwm_level    = wave_rd_data;
    assign m_red_led      = led_reg[0];
    assign m_green_led    = led_reg[1];
    assign m_blue_led     = led_reg[2];
    assign m_note_number  = note_pos_reg;
    assign m_sample_start = start_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_busy_reg |-> !s_ready)
        else $error("input taken during table load");

    a_note_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && note_step) |=> !s_ready)
        else $error("input taken before new note entry was read");

    a_idle_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !s_tick) |=> ($stable(note_pos_reg) && $stable(wave_pos_reg)
                                 && $stable(led_reg)))
        else $error("zero tick changed sequencer state");

    a_note_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, note_pos_reg} < SONG_LEN_W)
        else $error("note index beyond song");

    a_wave_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wave_pos_reg} < WAVE_LEN_W)
        else $error("wave index beyond waveform");
`endif

endmodule

>>> rtl/core/wts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the waveform and note tables of the sequencer.
`timescale 1ns / 1ps

module wts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 92
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for wavetable_tone_sequencer: tick beats in, tone beats out.
// Predicts every tone beat from its own copy of the waveform and song tables.
// Depends on rtl/core/wts_pkg.sv and rtl/core/wavetable_tone_sequencer.sv.
`timescale 1ns / 1ps

module testbench;

    localparam int WAVE_LEN     = 92;
    localparam int NOTE_COUNT   = 72;
    localparam int WAVE_ROM_LEN = 92;
    localparam int NOTE_ROM_LEN = 72;
    localparam int SONG_LEN     = (NOTE_COUNT < NOTE_ROM_LEN) ? NOTE_COUNT : NOTE_ROM_LEN;
    localparam int MAX_REPORTS  = 10;

    // Entry 0 sits in the top byte.
    localparam logic [WAVE_ROM_LEN*8-1:0] WAVE_SHAPE = {
        8'h8a, 8'hb1, 8'h55, 8'h4d, 8'hb2, 8'h90, 8'h43, 8'h8f, 8'hb7, 8'h4f, 8'h54, 8'hbd,
        8'h8c, 8'h35, 8'h98, 8'hb8, 8'h3a, 8'h70, 8'hcb, 8'h4c, 8'h51, 8'hd7, 8'h5d, 8'h47,
        8'hd2, 8'h69, 8'h3a, 8'hde, 8'h54, 8'h4c, 8'he4, 8'h30, 8'h7b, 8'hcf, 8'h0f, 8'hc5,
        8'h82, 8'h2e, 8'hf3, 8'h13, 8'hb2, 8'h91, 8'h2c, 8'hf5, 8'h01, 8'he0, 8'h45, 8'h83,
        8'ha8, 8'h2e, 8'he9, 8'h05, 8'hf6, 8'h13, 8'hd3, 8'h47, 8'h96, 8'h80, 8'h61, 8'hac,
        8'h3e, 8'hc9, 8'h26, 8'hdc, 8'h1d, 8'hdc, 8'h27, 8'hc6, 8'h43, 8'ha8, 8'h60, 8'h89,
        8'h83, 8'h65, 8'hac, 8'h40, 8'hc6, 8'h30, 8'hc2, 8'h45, 8'ha0, 8'h74, 8'h6e, 8'ha5,
        8'h46, 8'hba, 8'h4b, 8'h94, 8'h89, 8'h56, 8'hb7, 8'h59
    };

    // Each note is {rate, duration}; note 0 sits in the top 24 bits.
    localparam logic [NOTE_ROM_LEN*24-1:0] SONG = {
        8'd100, 16'd280,  8'd150, 16'd250,  8'd180, 16'd300,  8'd90, 16'd800,
        8'd120, 16'd500,  8'd200, 16'd50,   8'd120, 16'd280,  8'd95, 16'd282,
        8'd90, 16'd285,   8'd180, 16'd350,  8'd150, 16'd380,  8'd120, 16'd280,
        8'd95, 16'd410,   8'd90, 16'd285,   8'd70, 16'd500,   8'd200, 16'd50,
        8'd70, 16'd180,   8'd65, 16'd1000,  8'd70, 16'd150,   8'd80, 16'd180,
        8'd90, 16'd285,   8'd80, 16'd270,   8'd12, 16'd50,    8'd50, 16'd2000,
        8'd200, 16'd500,  8'd80, 16'd500,   8'd100, 16'd500,  8'd255, 16'd800,
        8'd100, 16'd100,  8'd96, 16'd100,   8'd92, 16'd100,   8'd88, 16'd200,
        8'd84, 16'd250,   8'd80, 16'd300,   8'd77, 16'd350,   8'd74, 16'd400,
        8'd71, 16'd200,   8'd68, 16'd200,   8'd65, 16'd200,   8'd62, 16'd200,
        8'd59, 16'd190,   8'd56, 16'd180,   8'd53, 16'd170,   8'd53, 16'd160,
        8'd50, 16'd150,   8'd48, 16'd140,   8'd46, 16'd130,   8'd44, 16'd120,
        8'd42, 16'd110,   8'd40, 16'd100,   8'd38, 16'd100,   8'd36, 16'd100,
        8'd34, 16'd100,   8'd32, 16'd100,   8'd30, 16'd100,   8'd28, 16'd100,
        8'd26, 16'd100,   8'd24, 16'd100,   8'd22, 16'd90,    8'd20, 16'd70,
        8'd18, 16'd60,    8'd16, 16'd50,    8'd14, 16'd40,    8'd10, 16'd100,
        8'd16, 16'd50,    8'd20, 16'd70,    8'd36, 16'd100,   8'd50, 16'd150,
        8'd62, 16'd200,   8'd71, 16'd200,   8'd80, 16'd150,   8'd92, 16'd130
    };

    typedef struct packed {
        logic [7:0] pwm_level;
        logic       red_led;
        logic       green_led;
        logic       blue_led;
        logic [6:0] note_number;
        logic       sample_start;
    } tone_beat_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [16:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_tick      = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_pwm_level;
    logic        m_red_led;
    logic        m_green_led;
    logic        m_blue_led;
    logic [6:0]  m_note_number;
    logic        m_sample_start;

    // Predicted sequencer state
    logic [16:0] unit_ticks_now = 17'd11;
    logic [16:0] tick_cnt       = '0;
    logic [7:0]  hold_cnt       = '0;
    logic [15:0] sample_cnt     = '0;
    logic [6:0]  wave_idx       = '0;
    logic [6:0]  note_idx       = '0;
    logic [2:0]  leds           = '0;

    tone_beat_t  tone_beats_due[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    wavetable_tone_sequencer #(
        .WAVE_LEN   (WAVE_LEN),
        .NOTE_COUNT (NOTE_COUNT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_level    (m_pwm_level),
        .m_red_led      (m_red_led),
        .m_green_led    (m_green_led),
        .m_blue_led     (m_blue_led),
        .m_note_number  (m_note_number),
        .m_sample_start (m_sample_start)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Advance the predicted state by one tick beat and return the tone beat it yields.
    function automatic tone_beat_t advance_sequencer(input logic tick_in);
        tone_beat_t  beat;
        logic [7:0]  rate;
        logic [15:0] dur;
        logic        started;
        started = 1'b0;
        if (tick_in) begin
            {rate, dur} = (note_idx < NOTE_ROM_LEN) ?
                          SONG[(NOTE_ROM_LEN - 1 - note_idx) * 24 +: 24] : 24'h0;
            if (tick_cnt + 1 >= unit_ticks_now) begin
                tick_cnt = '0;
                if (hold_cnt + 1 >= rate) begin
                    hold_cnt = '0;
                    started  = 1'b1;
                    wave_idx = wave_idx + 1;
                    if (wave_idx >= WAVE_LEN) begin
                        wave_idx = '0;
                        if (rate % 50 == 0 || rate % 20 == 0) leds[0] = ~leds[0];
                        if (rate % 40 == 0 || rate % 10 == 0) leds[1] = ~leds[1];
                    end
                    if (sample_cnt + 1 >= dur) begin
                        sample_cnt = '0;
                        leds[2]    = ~leds[2];
                        note_idx   = note_idx + 1;
                        // past the last note: restart the song from the top
                        if (note_idx >= SONG_LEN) begin
                            note_idx   = '0;
                            wave_idx   = '0;
                        end
                    end else begin
                        sample_cnt = sample_cnt + 1;
                    end
                end else begin
                    hold_cnt = hold_cnt + 1;
                end
            end else begin
                tick_cnt = tick_cnt + 1;
            end
        end
        beat.pwm_level    = (wave_idx < WAVE_ROM_LEN) ?
                            WAVE_SHAPE[(WAVE_ROM_LEN - 1 - wave_idx) * 8 +: 8] : 8'h00;
        beat.red_led      = leds[0];
        beat.green_led    = leds[1];
        beat.blue_led     = leds[2];
        beat.note_number  = note_idx;
        beat.sample_start = started;
        return beat;
    endfunction

    task automatic log_mismatch(input string what, input tone_beat_t want, input tone_beat_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t %s: expected pwm %0d r%0d g%0d b%0d note %0d start %0d",
                     $time, what, want.pwm_level, want.red_led, want.green_led,
                     want.blue_led, want.note_number, want.sample_start);
            $display("    actual pwm %0d r%0d g%0d b%0d note %0d start %0d",
                     got.pwm_level, got.red_led, got.green_led,
                     got.blue_led, got.note_number, got.sample_start);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        tone_beat_t want;
        tone_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_pwm_level, m_red_led, m_green_led, m_blue_led,
                   m_note_number, m_sample_start};
            if (tone_beats_due.size() == 0) begin
                log_mismatch("tone beat with none due", '0, got);
            end else begin
                want = tone_beats_due.pop_front();
                if (got.pwm_level !== want.pwm_level || got.red_led !== want.red_led ||
                    got.green_led !== want.green_led || got.blue_led !== want.blue_led ||
                    got.note_number !== want.note_number ||
                    got.sample_start !== want.sample_start) begin
                    log_mismatch("tone beat mismatch", want, got);
                end
            end
        end
    end

    task automatic send_tick(input logic tick_val);
        tone_beat_t beat;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_tick  <= tick_val;
        do @(posedge aclk); while (!s_ready);
        beat = advance_sequencer(tick_val);
        tone_beats_due.push_back(beat);
    endtask

    // Hold off the sender until every predicted tone beat has come back.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tone_beats_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_unit_ticks(input logic [16:0] value);
        wait_for_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        unit_ticks_now = value;
    endtask

    // Idle beat, then the first unit boundary at the reset divider.
    task automatic test_reset_defaults();
        send_tick(1'b0);
        repeat (11) send_tick(1'b1);
    endtask

    // Zero and one divider, the widest values, and a divider lowered mid-count.
    task automatic test_unit_extremes();
        write_unit_ticks(17'd0);
        repeat (3) send_tick(1'b1);
        write_unit_ticks(17'h1FFFF);
        repeat (2) send_tick(1'b1);
        write_unit_ticks(17'd2);
        send_tick(1'b1);
        write_unit_ticks(17'h10000);
        send_tick(1'b1);
        write_unit_ticks(17'd1);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_random_ticks(input int n_items, input int send_pct, input int recv_pct);
        int          sent;
        int          seg;
        logic [16:0] unit;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: unit = 17'($urandom_range(0, 3));
                6, 7:             unit = 17'($urandom_range(4, 24));
                8:                unit = 17'($urandom_range(0, 17'h1FFFF));
                default:          unit = $urandom_range(0, 1) ? 17'h1FFFF : 17'h10000;
            endcase
            write_unit_ticks(unit);
            seg = $urandom_range(20, 160);
            repeat (seg) send_tick($urandom_range(0, 7) != 0);
            sent += seg;
        end
    endtask

    // Back-to-back ticks at a divider of one: a sample starts every rate ticks.
    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_unit_ticks(17'd1);
        repeat (200) send_tick(1'b1);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_unit_extremes();
        test_random_ticks(600, 7, 59);
        test_random_ticks(600, 59, 7);
        test_random_ticks(600, 0, 0);
        test_full_rate();
        wait_for_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && tone_beats_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
